### src/hrgb_pkg.sv
// Package with the item types, fixed-point constants and helper functions of the colour converter.
package hrgb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QW = FRAC_BITS + 1;
  localparam int VW = FRAC_BITS + 2;
  localparam int IN_W = 17;
  localparam int SCALE_UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SCALE_DN = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
  localparam logic [IN_W-1:0] ONE_Q16 = IN_W'(65536);
  localparam logic [QW-1:0] ONE_F = QW'(1) << FRAC_BITS;

  typedef struct packed {
    logic [15:0]     hue;
    logic [IN_W-1:0] brightness;
    logic [IN_W-1:0] saturation;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_byte;
    logic [7:0] green_byte;
    logic [7:0] blue_byte;
  } out_item_t;

  typedef enum logic [2:0] {
    SEC_RED_MAG    = 3'd0,
    SEC_RED_YEL    = 3'd1,
    SEC_GRN_YEL    = 3'd2,
    SEC_GRN_CYN    = 3'd3,
    SEC_BLU_CYN    = 3'd4,
    SEC_BLU_MAG    = 3'd5
  } sector_t;

  function automatic logic [QW-1:0] scale_q16(input logic [IN_W-1:0] x);
    logic [IN_W+23:0] t;
    t = {24'b0, x};
    t = (t << SCALE_UP) >> SCALE_DN;
    return t[QW-1:0];
  endfunction

  function automatic logic [7:0] to_byte(input logic [VW-1:0] v);
    logic [7:0] res;
    if (v[VW-1:FRAC_BITS] != '0) begin
      res = 8'hFF;
    end else begin
      res = v[FRAC_BITS-1 -: 8];
    end
    return res;
  endfunction

endpackage

### src/hrgb_front.sv
// First pipeline stage: clamping, sector split of the hue and base colour selection.
module hrgb_front (
  input  logic                    clk,
  input  logic                    en,
  input  hrgb_pkg::in_item_t      item,
  output logic [hrgb_pkg::QW-1:0] b_r,
  output logic [hrgb_pkg::QW-1:0] s_r,
  output logic [hrgb_pkg::QW-1:0] d_r,
  output logic [hrgb_pkg::QW-1:0] cr_r,
  output logic [hrgb_pkg::QW-1:0] cg_r,
  output logic [hrgb_pkg::QW-1:0] cb_r
);

  logic [hrgb_pkg::IN_W-1:0] bc;
  logic [hrgb_pkg::IN_W-1:0] sc;
  logic [hrgb_pkg::QW-1:0]   b_nxt;
  logic [hrgb_pkg::QW-1:0]   s_nxt;
  logic [hrgb_pkg::QW-1:0]   d_nxt;
  logic [hrgb_pkg::QW-1:0]   cr_nxt;
  logic [hrgb_pkg::QW-1:0]   cg_nxt;
  logic [hrgb_pkg::QW-1:0]   cb_nxt;
  logic [hrgb_pkg::QW-1:0]   f;
  logic [hrgb_pkg::QW-1:0]   nf;
  logic [18:0]               h6;
  hrgb_pkg::sector_t         sector;

  always_comb begin
    bc = (item.brightness > hrgb_pkg::ONE_Q16) ? hrgb_pkg::ONE_Q16 : item.brightness;
    sc = (item.saturation > hrgb_pkg::ONE_Q16) ? hrgb_pkg::ONE_Q16 : item.saturation;
    b_nxt = hrgb_pkg::scale_q16(bc);
    s_nxt = hrgb_pkg::scale_q16(sc);
    d_nxt = (b_nxt > s_nxt) ? b_nxt - s_nxt : '0;
    h6 = {3'b0, item.hue} * 19'd6;
    sector = hrgb_pkg::sector_t'(h6[18:16]);
    f = hrgb_pkg::scale_q16({1'b0, h6[15:0]});
    nf = hrgb_pkg::ONE_F - f;
    case (sector)
      hrgb_pkg::SEC_RED_MAG: begin
        cr_nxt = hrgb_pkg::ONE_F; cg_nxt = '0; cb_nxt = nf;
      end
      hrgb_pkg::SEC_RED_YEL: begin
        cr_nxt = hrgb_pkg::ONE_F; cg_nxt = f; cb_nxt = '0;
      end
      hrgb_pkg::SEC_GRN_YEL: begin
        cr_nxt = nf; cg_nxt = hrgb_pkg::ONE_F; cb_nxt = '0;
      end
      hrgb_pkg::SEC_GRN_CYN: begin
        cr_nxt = '0; cg_nxt = hrgb_pkg::ONE_F; cb_nxt = f;
      end
      hrgb_pkg::SEC_BLU_CYN: begin
        cr_nxt = '0; cg_nxt = nf; cb_nxt = hrgb_pkg::ONE_F;
      end
      default: begin
        cr_nxt = f; cg_nxt = '0; cb_nxt = hrgb_pkg::ONE_F;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r  <= b_nxt;
      s_r  <= s_nxt;
      d_r  <= d_nxt;
      cr_r <= cr_nxt;
      cg_r <= cg_nxt;
      cb_r <= cb_nxt;
    end
  end

endmodule

### src/hrgb_shade.sv
// Two multiply stages that shade one colour channel.
module hrgb_shade (
  input  logic                    clk,
  input  logic                    en,
  input  logic [hrgb_pkg::QW-1:0] b,
  input  logic [hrgb_pkg::QW-1:0] s,
  input  logic [hrgb_pkg::QW-1:0] d,
  input  logic [hrgb_pkg::QW-1:0] c,
  output logic [hrgb_pkg::VW-1:0] v_r
);

  logic [2*hrgb_pkg::QW-1:0] dc;
  logic [hrgb_pkg::QW-1:0]   p_nxt;
  logic [hrgb_pkg::QW-1:0]   p_r;
  logic [hrgb_pkg::QW-1:0]   s_r;
  logic [hrgb_pkg::QW-1:0]   b_r;
  logic [hrgb_pkg::QW:0]     inner;
  logic [2*hrgb_pkg::QW:0]   bv;
  logic [hrgb_pkg::VW-1:0]   v_nxt;

  always_comb begin
    dc = {{hrgb_pkg::QW{1'b0}}, d} * {{hrgb_pkg::QW{1'b0}}, c};
    p_nxt = dc[hrgb_pkg::FRAC_BITS +: hrgb_pkg::QW];
    inner = {1'b0, p_r} + {1'b0, s_r};
    bv = {{(hrgb_pkg::QW+1){1'b0}}, b_r} * {{hrgb_pkg::QW{1'b0}}, inner};
    v_nxt = bv[hrgb_pkg::FRAC_BITS +: hrgb_pkg::VW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
      s_r <= s;
      b_r <= b;
      v_r <= v_nxt;
    end
  end

endmodule

### src/hue_to_rgb_bytes.sv
// Top level of the hue, brightness and saturation to RGB byte converter.
// An accepted item passes through the front stage, the two shade stages and the output register to its result.
// Throughput is one item per cycle; the four register stages advance together when not stalled.
// The whole pipeline holds while the output register is full and stalled.
// Synchronous active-low reset clears the valid bits only; data registers are not reset.
module hue_to_rgb_bytes (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hrgb_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hrgb_pkg::out_item_t  out_item
);

  logic                    en;
  logic                    v1_r;
  logic                    v2_r;
  logic                    v3_r;
  logic                    out_valid_r;
  hrgb_pkg::out_item_t     out_item_r;
  hrgb_pkg::out_item_t     out_item_nxt;
  logic [hrgb_pkg::QW-1:0] b1;
  logic [hrgb_pkg::QW-1:0] s1;
  logic [hrgb_pkg::QW-1:0] d1;
  logic [hrgb_pkg::QW-1:0] cr1;
  logic [hrgb_pkg::QW-1:0] cg1;
  logic [hrgb_pkg::QW-1:0] cb1;
  logic [hrgb_pkg::VW-1:0] vr;
  logic [hrgb_pkg::VW-1:0] vg;
  logic [hrgb_pkg::VW-1:0] vb;

  assign en = !out_valid_r || !out_stall;
  assign in_stall = !en;
  assign out_valid = out_valid_r;
  assign out_item = out_item_r;

  hrgb_front u_front (
    .clk  (clk),
    .en   (en),
    .item (in_item),
    .b_r  (b1),
    .s_r  (s1),
    .d_r  (d1),
    .cr_r (cr1),
    .cg_r (cg1),
    .cb_r (cb1)
  );

  hrgb_shade u_shade_r (
    .clk (clk), .en (en), .b (b1), .s (s1), .d (d1), .c (cr1), .v_r (vr)
  );

  hrgb_shade u_shade_g (
    .clk (clk), .en (en), .b (b1), .s (s1), .d (d1), .c (cg1), .v_r (vg)
  );

  hrgb_shade u_shade_b (
    .clk (clk), .en (en), .b (b1), .s (s1), .d (d1), .c (cb1), .v_r (vb)
  );

  always_comb begin
    out_item_nxt.red_byte   = hrgb_pkg::to_byte(vr);
    out_item_nxt.green_byte = hrgb_pkg::to_byte(vg);
    out_item_nxt.blue_byte  = hrgb_pkg::to_byte(vb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule
